/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the infrared frame transmitter.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/irpw_pkg.sv */
// Package of the infrared pulse-width frame transmitter: phase codes,
// register indexes, reset values and parameter defaults. No dependencies.
`default_nettype none

package irpw_pkg;

  localparam int FRAME_BITS_DEF = 8;
  localparam int GAP_CW_DEF     = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  localparam logic [7:0]  CARRIER_HIGH_RST = 8'd7;
  localparam logic [7:0]  CARRIER_LOW_RST  = 8'd20;
  localparam logic [7:0]  START_PER_RST    = 8'd89;
  localparam logic [7:0]  ONE_PER_RST      = 8'd45;
  localparam logic [7:0]  ZERO_PER_RST     = 8'd22;
  localparam logic [11:0] GAP_US_RST       = 12'd600;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_BURST = 3'b010,
    PH_GAP   = 3'b100
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_HIGH = 3'd0,
    REG_CARRIER_LOW  = 3'd1,
    REG_START_PER    = 3'd2,
    REG_ONE_PER      = 3'd3,
    REG_ZERO_PER     = 3'd4,
    REG_GAP_US       = 3'd5
  } reg_idx_t;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SEND = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/ir_pulse_width_frame_transmitter.sv */
// Infrared pulse-width frame transmitter on a modulated carrier.
// Depends on irpw_pkg and assert_macros.svh.
//
// Input channel: each word is a tick (in_tuser = 0), standing for one
// microsecond, or a send (in_tuser = 1) that loads the byte in in_tdata and
// starts a frame. A send while a frame is under way is dropped and flagged.
// A frame is a start burst and a gap, then FRAME_BITS data bits, LSB first,
// each a long or short carrier burst followed by a gap.
// Output channel: exactly one word per input word, carrying the LED level
// for that tick, the busy flag and the reject flag in out_tdata, and the
// end-of-frame flag on out_tlast.
// Configuration channel: cfg_index selects a timing register, cfg_data holds
// the value; it is always ready, and the user must write it only while the
// block is idle; the block itself does not enforce it. Output valid rises
// in the cycle after input accept. One word is accepted every cycle while
// the output register is empty or being drained, and a stalled receiver
// holds the output word; the frame timer and output register are the only
// stages. Reset loads the default timing (38 kHz style carrier) and leaves
// the transmitter idle with the output register empty.
`default_nettype none

module ir_pulse_width_frame_transmitter
  import irpw_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF,
  parameter int GAP_CW     = GAP_CW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] command_byte
  input  wire logic [0:0]            in_tuser,   // [0] kind
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [0] led_on, [1] busy_res,
                                                 // [2] rejected
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BPW  = $clog2(FRAME_BITS + 1);
  localparam int GW_IN = (GAP_CW < CFG_DATA_W) ? GAP_CW : CFG_DATA_W;

  logic [7:0]        carrier_high_r, carrier_low_r, start_per_r, one_per_r, zero_per_r;
  logic [GAP_CW-1:0] gap_us_r;

  phase_t            phase_r, phase_nxt;
  logic [BPW-1:0]    bit_pos_r, bit_pos_nxt;
  logic [FRAME_BITS-1:0] data_r, data_nxt;
  logic [7:0]        per_cnt_r, per_cnt_nxt, per_inc, burst_len;
  logic [GAP_CW-1:0] us_cnt_r, us_cnt_nxt, us_inc;
  logic              carrier_r, carrier_nxt;

  logic              in_acc, active;
  logic              led, busy, done, rej;
  logic              out_tvalid_r;
  logic [3:0]        res_r;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-3){1'b0}}, res_r[3], res_r[1:0]};
  assign out_tlast  = res_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_high_r <= CARRIER_HIGH_RST;
      carrier_low_r  <= CARRIER_LOW_RST;
      start_per_r    <= START_PER_RST;
      one_per_r      <= ONE_PER_RST;
      zero_per_r     <= ZERO_PER_RST;
      gap_us_r       <= GAP_CW'(GAP_US_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CARRIER_HIGH: carrier_high_r <= cfg_data[7:0];
        REG_CARRIER_LOW:  carrier_low_r  <= cfg_data[7:0];
        REG_START_PER:    start_per_r    <= cfg_data[7:0];
        REG_ONE_PER:      one_per_r      <= cfg_data[7:0];
        REG_ZERO_PER:     zero_per_r     <= cfg_data[7:0];
        REG_GAP_US:       gap_us_r       <= GAP_CW'(cfg_data[GW_IN-1:0]);
        default: ;
      endcase
    end
  end

  assign active    = (phase_r == PH_BURST) || (phase_r == PH_GAP);
  assign us_inc    = us_cnt_r + GAP_CW'(1);
  assign per_inc   = per_cnt_r + 8'd1;
  assign burst_len = (bit_pos_r == '0) ? start_per_r :
                     (data_r[0] ? one_per_r : zero_per_r);

  always_comb begin
    phase_nxt   = phase_r;
    bit_pos_nxt = bit_pos_r;
    data_nxt    = data_r;
    per_cnt_nxt = per_cnt_r;
    us_cnt_nxt  = us_cnt_r;
    carrier_nxt = carrier_r;
    led  = 1'b0;
    busy = 1'b0;
    done = 1'b0;
    rej  = 1'b0;
    if (in_tuser[0] == KIND_SEND) begin
      busy = 1'b1;
      if (active) begin
        rej = 1'b1;
      end else begin
        phase_nxt   = PH_BURST;
        bit_pos_nxt = '0;
        data_nxt    = FRAME_BITS'(in_tdata);
        per_cnt_nxt = '0;
        us_cnt_nxt  = '0;
        carrier_nxt = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_BURST: begin
          busy       = 1'b1;
          led        = carrier_r;
          us_cnt_nxt = us_inc;
          if (carrier_r) begin
            if (us_inc >= GAP_CW'(carrier_high_r)) begin
              carrier_nxt = 1'b0;
              us_cnt_nxt  = '0;
            end
          end else if (us_inc >= GAP_CW'(carrier_low_r)) begin
            us_cnt_nxt  = '0;
            per_cnt_nxt = per_inc;
            if (per_inc >= burst_len) begin
              phase_nxt = PH_GAP;
            end else begin
              carrier_nxt = 1'b1;
            end
          end
        end
        PH_GAP: begin
          busy       = 1'b1;
          us_cnt_nxt = us_inc;
          if (us_inc >= gap_us_r) begin
            us_cnt_nxt = '0;
            if (bit_pos_r >= BPW'(FRAME_BITS)) begin
              phase_nxt   = PH_IDLE;
              bit_pos_nxt = '0;
              done        = 1'b1;
            end else begin
              if (bit_pos_r != '0) begin
                data_nxt = data_r >> 1;
              end
              bit_pos_nxt = bit_pos_r + BPW'(1);
              per_cnt_nxt = '0;
              carrier_nxt = 1'b1;
              phase_nxt   = PH_BURST;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_pos_r    <= '0;
      data_r       <= '0;
      per_cnt_r    <= '0;
      us_cnt_r     <= '0;
      carrier_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r   <= phase_nxt;
        bit_pos_r <= bit_pos_nxt;
        data_r    <= data_nxt;
        per_cnt_r <= per_cnt_nxt;
        us_cnt_r  <= us_cnt_nxt;
        carrier_r <= carrier_nxt;
      end
      if (in_acc) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= {rej, done, busy, led};
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMP(a_idle_pos, clk, rst_n, phase_r == PH_IDLE, bit_pos_r == '0, "idle with bit position set")
  `ASSERT_NXT(a_done_idle, clk, rst_n, in_acc && done, phase_r == PH_IDLE, "frame end did not go idle")
  `ASSERT_IMP(a_led_busy, clk, rst_n, out_tvalid_r && res_r[0], res_r[1] && !res_r[3], "LED on outside a frame")

endmodule

`default_nettype wire
